// File: rtl/saru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saru_pkg
// Shared types and event codes for the scroll address register unit.
// ----------------------------------------------------------------------------
package saru_pkg;

    // Event codes carried in the op field
    localparam logic [2:0] OP_CTRL   = 3'd0;
    localparam logic [2:0] OP_SCROLL = 3'd1;
    localparam logic [2:0] OP_ADDR   = 3'd2;
    localparam logic [2:0] OP_DATA   = 3'd3;
    localparam logic [2:0] OP_STATUS = 3'd4;
    localparam logic [2:0] OP_TILE   = 3'd5;
    localparam logic [2:0] OP_LINE   = 3'd6;
    localparam logic [2:0] OP_FRAME  = 3'd7;

    // Bit groups of the video address
    localparam logic [14:0] VERT_BITS = 15'h7BE0;
    localparam logic [14:0] HORZ_BITS = 15'h041F;

    // Coarse Y rows with special wrap handling
    localparam logic [4:0] ROW_LAST_VISIBLE = 5'd29;
    localparam logic [4:0] ROW_MAX          = 5'd31;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
    } t_in_beat;

    typedef struct packed {
        logic [14:0] access_addr;
        logic [14:0] current_addr;
        logic [13:0] nt_fetch_addr;
        logic [13:0] at_fetch_addr;
        logic [1:0]  attr_quadrant;
        logic [2:0]  fine_y;
        logic [2:0]  fine_x_out;
        logic        toggle_out;
    } t_out_beat;

    // Architectural scroll state
    typedef struct packed {
        logic [14:0] temp_addr;
        logic [14:0] cur_addr;
        logic [2:0]  fine_x;
        logic        write_toggle;
        logic        step_by_32;
    } t_state;

endpackage

// File: rtl/saru_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saru_step
// Next-state and result logic for one event applied to the scroll state.
// ----------------------------------------------------------------------------
module saru_step (
    input  saru_pkg::t_state    i_state,
    input  saru_pkg::t_in_beat  i_beat,
    output saru_pkg::t_state    o_state,
    output saru_pkg::t_out_beat o_result
);
    import saru_pkg::*;

    logic [14:0] v;
    logic [14:0] tile_v;
    logic [14:0] line_v;
    logic [14:0] line_pre;
    logic [4:0]  row;
    logic [4:0]  row_next;
    logic        vflip;
    logic [7:0]  d;
    t_state      nxt;

    assign v = i_state.cur_addr;
    assign d = i_beat.data;

    // Horizontal step: coarse X wraps at 31 into the next nametable
    always_comb begin
        if (v[4:0] == 5'd31) begin
            tile_v = {v[14:11], ~v[10], v[9:5], 5'd0};
        end else begin
            tile_v = v + 15'd1;
        end
    end

    // Vertical step at line end, then horizontal reload from t
    always_comb begin
        row      = v[9:5];
        row_next = row + 5'd1;
        vflip    = 1'b0;
        if (row == ROW_LAST_VISIBLE) begin
            row_next = 5'd0;
            vflip    = 1'b1;
        end else if (row == ROW_MAX) begin
            row_next = 5'd0;
        end
        if (v[14:12] != 3'd7) begin
            line_pre = {v[14:12] + 3'd1, v[11:0]};
        end else begin
            line_pre = {3'd0, v[11] ^ vflip, v[10], row_next, v[4:0]};
        end
        line_v = (line_pre & ~HORZ_BITS) | (i_state.temp_addr & HORZ_BITS);
    end

    // Event decode
    always_comb begin
        nxt = i_state;
        unique case (i_beat.op)
            OP_CTRL: begin
                nxt.step_by_32      = d[2];
                nxt.temp_addr[11:10] = d[1:0];
            end
            OP_SCROLL: begin
                if (!i_state.write_toggle) begin
                    nxt.fine_x          = d[2:0];
                    nxt.temp_addr[4:0]  = d[7:3];
                end else begin
                    nxt.temp_addr[9:5]   = d[7:3];
                    nxt.temp_addr[14:12] = d[2:0];
                end
                nxt.write_toggle = ~i_state.write_toggle;
            end
            OP_ADDR: begin
                if (!i_state.write_toggle) begin
                    nxt.temp_addr[14]   = 1'b0;
                    nxt.temp_addr[13:8] = d[5:0];
                end else begin
                    nxt.temp_addr[7:0] = d;
                    nxt.cur_addr       = {i_state.temp_addr[14:8], d};
                end
                nxt.write_toggle = ~i_state.write_toggle;
            end
            OP_DATA: begin
                nxt.cur_addr = v + (i_state.step_by_32 ? 15'd32 : 15'd1);
            end
            OP_STATUS: begin
                nxt.write_toggle = 1'b0;
            end
            OP_TILE: begin
                nxt.cur_addr = tile_v;
            end
            OP_LINE: begin
                nxt.cur_addr = line_v;
            end
            default: begin
                nxt.cur_addr = (v & ~VERT_BITS) | (i_state.temp_addr & VERT_BITS);
            end
        endcase
    end

    assign o_state = nxt;

    // Derived fetch addresses from the updated address; access_addr is the address before the update
    always_comb begin
        o_result.access_addr   = v;
        o_result.current_addr  = nxt.cur_addr;
        o_result.nt_fetch_addr = {2'b10, nxt.cur_addr[11:0]};
        o_result.at_fetch_addr = {2'b10, nxt.cur_addr[11:10], 4'b1111,
                                  nxt.cur_addr[9:7], nxt.cur_addr[4:2]};
        o_result.attr_quadrant = {nxt.cur_addr[6], nxt.cur_addr[1]};
        o_result.fine_y        = nxt.cur_addr[14:12];
        o_result.fine_x_out    = nxt.fine_x;
        o_result.toggle_out    = nxt.write_toggle;
    end

endmodule

// File: rtl/scroll_address_register_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scroll_address_register_unit
// Scroll and video address registers: applies one event per beat and reports
// the access, nametable and attribute addresses.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall  | t_in_beat  (op, data)
//  out     | output    | o_out_valid / i_out_stall | t_out_beat (addresses)
//
//  One beat per cycle while o_in_stall is low; results are registered.
//  State updates at the accepting edge, so events chain back to back.
//  A two-entry output buffer (output register plus skid) lets one more beat
//  in while a result is stalled; o_in_stall is the skid-full flag.
//  Synchronous active-low reset clears the state and empties the buffer.
// ----------------------------------------------------------------------------
module scroll_address_register_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  saru_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output saru_pkg::t_out_beat o_out_data
);
    import saru_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_out_beat n_result;
    t_out_beat r_out;
    t_out_beat r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    logic      in_acc;
    logic      out_free;

    saru_step u_step (
        .i_state  (r_state),
        .i_beat   (i_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    // Scroll state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_acc;
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_acc) begin
            r_skid <= n_result;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while output register is empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("beat accepted under stall was not parked in skid");

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.op == OP_STATUS) |=> !r_state.write_toggle)
        else $error("status read did not clear write toggle");

    a_cur_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_state))
        else $error("scroll state changed without an accepted beat");
`endif

endmodule
